/* design/rfbsmp_pkg.sv */
// Shared types and constants for the remote framebuffer server message parser.
// Used by rfbsmp_cfg, rfbsmp_parser, rfbsmp_outq and rfb_server_message_parser.
// No dependencies.
package rfbsmp_pkg;

  typedef enum logic [1:0] {
    EV_PIXEL     = 2'd0,
    EV_RECT_DONE = 2'd1,
    EV_ERROR     = 2'd2
  } ev_kind_e;

  typedef enum logic [2:0] {
    REG_FB_WIDTH         = 3'd0,
    REG_FB_HEIGHT        = 3'd1,
    REG_RED_LSB          = 3'd2,
    REG_GREEN_LSB        = 3'd3,
    REG_BLUE_LSB         = 3'd4,
    REG_PIXEL_BITS       = 3'd5,
    REG_PIXEL_BIG_ENDIAN = 3'd6
  } reg_idx_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] area_w;
    logic [15:0] area_h;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } event_t;

  typedef struct packed {
    logic [15:0] fb_width;
    logic [15:0] fb_height;
    logic [4:0]  red_lsb;
    logic [4:0]  green_lsb;
    logic [4:0]  blue_lsb;
    logic [5:0]  pixel_bits;
    logic        pixel_big_endian;
  } cfg_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Cut-text length limit: 32 MiB
  localparam logic [31:0] CutLimit    = 32'd33554432;
  localparam logic [5:0]  PixelBitsOk = 6'd32;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

endpackage

/* design/rfbsmp_cfg.sv */
// Configuration register file for the parser.
// Depends on rfbsmp_pkg.
module rfbsmp_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rfbsmp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rfbsmp_pkg::CfgDataW-1:0]  cfg_data_i,
  output rfbsmp_pkg::cfg_t                 cfg_o
);

  rfbsmp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_width         <= 16'd64;
      cfg_q.fb_height        <= 16'd64;
      cfg_q.red_lsb          <= 5'd16;
      cfg_q.green_lsb        <= 5'd8;
      cfg_q.blue_lsb         <= 5'd0;
      cfg_q.pixel_bits       <= 6'd32;
      cfg_q.pixel_big_endian <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (rfbsmp_pkg::reg_idx_e'(cfg_index_i))
        rfbsmp_pkg::REG_FB_WIDTH:         cfg_q.fb_width         <= cfg_data_i;
        rfbsmp_pkg::REG_FB_HEIGHT:        cfg_q.fb_height        <= cfg_data_i;
        rfbsmp_pkg::REG_RED_LSB:          cfg_q.red_lsb          <= cfg_data_i[4:0];
        rfbsmp_pkg::REG_GREEN_LSB:        cfg_q.green_lsb        <= cfg_data_i[4:0];
        rfbsmp_pkg::REG_BLUE_LSB:         cfg_q.blue_lsb         <= cfg_data_i[4:0];
        rfbsmp_pkg::REG_PIXEL_BITS:       cfg_q.pixel_bits       <= cfg_data_i[5:0];
        rfbsmp_pkg::REG_PIXEL_BIG_ENDIAN: cfg_q.pixel_big_endian <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/rfbsmp_parser.sv */
// Byte-at-a-time message parser: protocol state, rectangle walk, pixel unpack.
// Produces up to two events per accepted byte. Depends on rfbsmp_pkg.
module rfbsmp_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      byte_vld_i,
  input  logic [7:0]                byte_i,
  input  rfbsmp_pkg::cfg_t          cfg_i,
  output logic [1:0]                ev_cnt_o,
  output rfbsmp_pkg::event_t        ev0_o,
  output rfbsmp_pkg::event_t        ev1_o
);

  localparam logic [3:0] PH_MSG       = 4'd0;
  localparam logic [3:0] PH_FBU_PAD   = 4'd1;
  localparam logic [3:0] PH_FBU_COUNT = 4'd2;
  localparam logic [3:0] PH_RECT_HDR  = 4'd3;
  localparam logic [3:0] PH_RAW_PIX   = 4'd4;
  localparam logic [3:0] PH_COPY_SRC  = 4'd5;
  localparam logic [3:0] PH_CUT_PAD   = 4'd6;
  localparam logic [3:0] PH_CUT_LEN   = 4'd7;
  localparam logic [3:0] PH_CUT_SKIP  = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [15:0] rects_q, rects_d;
  logic [15:0] rx_q, rx_d, ry_q, ry_d, rw_q, rw_d, rh_q, rh_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic [31:0] asm_q, asm_d;
  logic [25:0] skip_q, skip_d;
  logic        err_q, err_d;

  logic [31:0] asm_shift;
  logic [3:0]  idx_inc;
  logic [15:0] rects_dec;
  logic [25:0] skip_dec;
  logic        oob;
  logic [31:0] pix_le, pix;
  logic [16:0] col_inc, row_inc;
  rfbsmp_pkg::event_t ev_err, ev_fin, ev_pix;
  rfbsmp_pkg::event_t ev0, ev1;
  logic [1:0]  n_ev;

  assign asm_shift = {asm_q[23:0], byte_i};
  assign idx_inc   = idx_q + 4'd1;
  assign rects_dec = rects_q - 16'd1;
  assign skip_dec  = skip_q - 26'd1;
  assign col_inc   = {1'b0, col_q} + 17'd1;
  assign row_inc   = {1'b0, row_q} + 17'd1;
  assign oob = ({1'b0, rx_q} + {1'b0, rw_q} > {1'b0, cfg_i.fb_width}) ||
               ({1'b0, ry_q} + {1'b0, rh_q} > {1'b0, cfg_i.fb_height});

  assign pix_le = {asm_shift[7:0], asm_shift[15:8], asm_shift[23:16], asm_shift[31:24]};
  assign pix    = cfg_i.pixel_big_endian ? asm_shift : pix_le;

  always_comb begin
    ev_err      = '0;
    ev_err.kind = rfbsmp_pkg::EV_ERROR;

    ev_fin        = '0;
    ev_fin.kind   = rfbsmp_pkg::EV_RECT_DONE;
    ev_fin.pos_x  = rx_q;
    ev_fin.pos_y  = ry_q;
    ev_fin.area_w = rw_q;
    ev_fin.area_h = rh_q;

    ev_pix       = '0;
    ev_pix.kind  = rfbsmp_pkg::EV_PIXEL;
    ev_pix.pos_x = rx_q + col_q;
    ev_pix.pos_y = ry_q + row_q;
    ev_pix.red   = 8'(pix >> cfg_i.red_lsb);
    ev_pix.green = 8'(pix >> cfg_i.green_lsb);
    ev_pix.blue  = 8'(pix >> cfg_i.blue_lsb);
  end

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    rects_d = rects_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    rw_d    = rw_q;
    rh_d    = rh_q;
    col_d   = col_q;
    row_d   = row_q;
    asm_d   = asm_q;
    skip_d  = skip_q;
    err_d   = err_q;
    ev0     = '0;
    ev1     = '0;
    n_ev    = 2'd0;

    if (byte_vld_i && !err_q) begin
      unique case (phase_q)
        PH_MSG: begin
          idx_d = '0;
          asm_d = '0;
          if (byte_i == 8'd0) begin
            phase_d = PH_FBU_PAD;
          end else if (byte_i == 8'd3) begin
            phase_d = PH_CUT_PAD;
          end else begin
            err_d = 1'b1;
            ev0   = ev_err;
            n_ev  = 2'd1;
          end
        end
        PH_FBU_PAD: begin
          phase_d = PH_FBU_COUNT;
        end
        PH_FBU_COUNT: begin
          asm_d = asm_shift;
          idx_d = idx_inc;
          if (idx_inc >= 4'd2) begin
            rects_d = asm_shift[15:0];
            idx_d   = '0;
            asm_d   = '0;
            phase_d = (asm_shift[15:0] != '0) ? PH_RECT_HDR : PH_MSG;
          end
        end
        PH_RECT_HDR: begin
          idx_d = idx_inc;
          if (idx_q < 4'd2)      rx_d = {rx_q[7:0], byte_i};
          else if (idx_q < 4'd4) ry_d = {ry_q[7:0], byte_i};
          else if (idx_q < 4'd6) rw_d = {rw_q[7:0], byte_i};
          else if (idx_q < 4'd8) rh_d = {rh_q[7:0], byte_i};
          else                   asm_d = asm_shift;
          if (idx_q >= 4'd11) begin
            idx_d = '0;
            if (asm_shift == 32'd0) begin
              if (oob || cfg_i.pixel_bits != rfbsmp_pkg::PixelBitsOk) begin
                err_d = 1'b1;
                ev0   = ev_err;
                n_ev  = 2'd1;
              end else if (rw_q == '0 || rh_q == '0) begin
                ev0     = ev_fin;
                n_ev    = 2'd1;
                rects_d = rects_dec;
                asm_d   = '0;
                phase_d = (rects_dec != '0) ? PH_RECT_HDR : PH_MSG;
              end else begin
                col_d   = '0;
                row_d   = '0;
                asm_d   = '0;
                phase_d = PH_RAW_PIX;
              end
            end else if (asm_shift == 32'd1) begin
              if (oob) begin
                err_d = 1'b1;
                ev0   = ev_err;
                n_ev  = 2'd1;
              end else begin
                asm_d   = '0;
                phase_d = PH_COPY_SRC;
              end
            end else begin
              err_d = 1'b1;
              ev0   = ev_err;
              n_ev  = 2'd1;
            end
          end
        end
        PH_RAW_PIX: begin
          asm_d = asm_shift;
          idx_d = idx_inc;
          if (idx_inc >= 4'd4) begin
            ev0   = ev_pix;
            n_ev  = 2'd1;
            idx_d = '0;
            asm_d = '0;
            col_d = col_inc[15:0];
            if (col_inc >= {1'b0, rw_q}) begin
              col_d = '0;
              row_d = row_inc[15:0];
              if (row_inc >= {1'b0, rh_q}) begin
                ev1     = ev_fin;
                n_ev    = 2'd2;
                rects_d = rects_dec;
                phase_d = (rects_dec != '0) ? PH_RECT_HDR : PH_MSG;
              end
            end
          end
        end
        PH_COPY_SRC: begin
          idx_d = idx_inc;
          if (idx_inc >= 4'd4) begin
            ev0     = ev_fin;
            n_ev    = 2'd1;
            idx_d   = '0;
            asm_d   = '0;
            rects_d = rects_dec;
            phase_d = (rects_dec != '0) ? PH_RECT_HDR : PH_MSG;
          end
        end
        PH_CUT_PAD: begin
          idx_d = idx_inc;
          if (idx_inc >= 4'd3) begin
            idx_d   = '0;
            asm_d   = '0;
            phase_d = PH_CUT_LEN;
          end
        end
        PH_CUT_LEN: begin
          asm_d = asm_shift;
          idx_d = idx_inc;
          if (idx_inc >= 4'd4) begin
            idx_d = '0;
            asm_d = '0;
            if (asm_shift > rfbsmp_pkg::CutLimit) begin
              err_d = 1'b1;
              ev0   = ev_err;
              n_ev  = 2'd1;
            end else begin
              skip_d  = asm_shift[25:0];
              phase_d = (asm_shift != '0) ? PH_CUT_SKIP : PH_MSG;
            end
          end
        end
        PH_CUT_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == '0) phase_d = PH_MSG;
        end
        default: begin
          phase_d = PH_MSG;
        end
      endcase
    end

    // flag the final event of this byte
    if (n_ev == 2'd1) ev0.last = 1'b1;
    if (n_ev == 2'd2) ev1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MSG;
      idx_q   <= '0;
      rects_q <= '0;
      rx_q    <= '0;
      ry_q    <= '0;
      rw_q    <= '0;
      rh_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
      asm_q   <= '0;
      skip_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      rects_q <= rects_d;
      rx_q    <= rx_d;
      ry_q    <= ry_d;
      rw_q    <= rw_d;
      rh_q    <= rh_d;
      col_q   <= col_d;
      row_q   <= row_d;
      asm_q   <= asm_d;
      skip_q  <= skip_d;
      err_q   <= err_d;
    end
  end

  assign ev_cnt_o = n_ev;
  assign ev0_o    = ev0;
  assign ev1_o    = ev1;

endmodule

/* design/rfbsmp_outq.sv */
// Small result queue: takes zero, one or two events per cycle, hands out one while out_ready_i is high.
// Depends on rfbsmp_pkg.
module rfbsmp_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_cnt_i,
  input  rfbsmp_pkg::event_t   push0_i,
  input  rfbsmp_pkg::event_t   push1_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rfbsmp_pkg::event_t   out_data_o
);

  rfbsmp_pkg::event_t              entry_q [rfbsmp_pkg::QDepth];
  logic [rfbsmp_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q, wr_ptr_nxt;
  logic [rfbsmp_pkg::QCntW-1:0]    count_q, count_d;
  logic                            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign wr_ptr_nxt  = wr_ptr_q + 1'b1;
  assign count_d     = count_q + rfbsmp_pkg::QCntW'(push_cnt_i)
                       - rfbsmp_pkg::QCntW'(pop);
  // room for the largest burst a single byte can cause
  assign room_o      = count_q <= rfbsmp_pkg::QCntW'(rfbsmp_pkg::QDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) entry_q[wr_ptr_q] <= push0_i;
    if (push_cnt_i == 2'd2) entry_q[wr_ptr_nxt] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + rfbsmp_pkg::QPtrW'(push_cnt_i);
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q  <= count_d;
    end
  end

endmodule

/* design/rfb_server_message_parser.sv */
// Channel   Direction  Handshake                  Payload
// rx        in         rx_valid_i / rx_ready_o    rx_byte_i
// ev        out        ev_valid_o / ev_ready_i    event_kind_o .. last_o
// cfg       in         cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// While rx_ready_o is high, one byte per cycle is parsed; its events are registered in the queue.
// The output port drains one event per cycle while ev_ready_i is high, so a byte ending a raw rectangle
// (pixel plus rectangle done) gives two events; a four-entry queue absorbs them.
// rx_ready_o drops only while the queue has fewer than two free entries.
// Reset clears parser state and the queue and loads register defaults.
// Depends on rfbsmp_pkg, rfbsmp_cfg, rfbsmp_parser, rfbsmp_outq.
module rfb_server_message_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rx_valid_i,
  output logic                             rx_ready_o,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             cfg_we_i,
  input  logic [rfbsmp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rfbsmp_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                             ev_valid_o,
  input  logic                             ev_ready_i,
  output logic [1:0]                       event_kind_o,
  output logic [15:0]                      pos_x_o,
  output logic [15:0]                      pos_y_o,
  output logic [15:0]                      area_width_o,
  output logic [15:0]                      area_height_o,
  output logic [7:0]                       red_o,
  output logic [7:0]                       green_o,
  output logic [7:0]                       blue_o,
  output logic                             last_o
);

  rfbsmp_pkg::cfg_t   cfg;
  rfbsmp_pkg::event_t ev0, ev1, ev_out;
  logic [1:0]         ev_cnt;
  logic               room;
  logic               rx_acc;

  assign rx_ready_o = room;
  assign rx_acc     = rx_valid_i && room;

  rfbsmp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rfbsmp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (rx_acc),
    .byte_i     (rx_byte_i),
    .cfg_i      (cfg),
    .ev_cnt_o   (ev_cnt),
    .ev0_o      (ev0),
    .ev1_o      (ev1)
  );

  rfbsmp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (ev_cnt),
    .push0_i     (ev0),
    .push1_i     (ev1),
    .room_o      (room),
    .out_valid_o (ev_valid_o),
    .out_ready_i (ev_ready_i),
    .out_data_o  (ev_out)
  );

  assign event_kind_o  = ev_out.kind;
  assign pos_x_o       = ev_out.pos_x;
  assign pos_y_o       = ev_out.pos_y;
  assign area_width_o  = ev_out.area_w;
  assign area_height_o = ev_out.area_h;
  assign red_o         = ev_out.red;
  assign green_o       = ev_out.green;
  assign blue_o        = ev_out.blue;
  assign last_o        = ev_out.last;

endmodule

/* tb/tb_rfb_server_message_parser.sv */
// Self-checking testbench for rfb_server_message_parser: drives the byte stream and
// config port, tracks expected events in a scoreboard class and compares each output.
// Depends on rfbsmp_pkg and the design files.
module tb_rfb_server_message_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import rfbsmp_pkg::*;

  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned RandomBytes  = 1600;
  localparam int unsigned NumSettings  = 8;
  localparam int unsigned PrintCap     = 200;
  localparam logic [7:0]  MsgUpdate    = 8'd0;
  localparam logic [7:0]  MsgCutText   = 8'd3;
  localparam logic [31:0] EncRaw       = 32'd0;
  localparam logic [31:0] EncCopy      = 32'd1;

  typedef enum {
    ST_MSG, ST_FBU_PAD, ST_FBU_COUNT, ST_RECT_HDR, ST_RAW_PIX,
    ST_COPY_SRC, ST_CUT_PAD, ST_CUT_LEN, ST_CUT_SKIP
  } parse_stage_e;

  typedef enum {
    BAD_TYPE, BAD_ENCODING, BAD_BOUNDS, BAD_DEPTH, BAD_TEXT_LEN
  } fault_e;

  class fb_event_tracker;
    cfg_t         cfg;
    parse_stage_e stage;
    int unsigned  field_idx;
    logic [15:0]  rects_left, rect_x, rect_y, rect_w, rect_h, col, row;
    logic [31:0]  word;
    logic [25:0]  skip_left;
    bit           halted;
    event_t       pending_events[$];
    int unsigned  mismatches;

    function new();
      cfg = '{fb_width: 16'd64, fb_height: 16'd64, red_lsb: 5'd16, green_lsb: 5'd8,
              blue_lsb: 5'd0, pixel_bits: 6'd32, pixel_big_endian: 1'b0};
      stage = ST_MSG;
      field_idx = 0;
      rects_left = '0; rect_x = '0; rect_y = '0; rect_w = '0; rect_h = '0;
      col = '0; row = '0; word = '0; skip_left = '0;
      halted = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [15:0] val);
      case (idx)
        REG_FB_WIDTH:         cfg.fb_width = val;
        REG_FB_HEIGHT:        cfg.fb_height = val;
        REG_RED_LSB:          cfg.red_lsb = val[4:0];
        REG_GREEN_LSB:        cfg.green_lsb = val[4:0];
        REG_BLUE_LSB:         cfg.blue_lsb = val[4:0];
        REG_PIXEL_BITS:       cfg.pixel_bits = val[5:0];
        REG_PIXEL_BIG_ENDIAN: cfg.pixel_big_endian = val[0];
        default: ;
      endcase
    endfunction

    function void add_event(ev_kind_e kind, logic [15:0] x, logic [15:0] y, logic [15:0] w,
                            logic [15:0] h, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      event_t e;
      e = '{kind: kind, pos_x: x, pos_y: y, area_w: w, area_h: h,
            red: r, green: g, blue: b, last: 1'b0};
      pending_events.push_back(e);
    endfunction

    function void raise_fault();
      halted = 1'b1;
      add_event(EV_ERROR, '0, '0, '0, '0, '0, '0, '0);
    endfunction

    function void close_rect();
      add_event(EV_RECT_DONE, rect_x, rect_y, rect_w, rect_h, '0, '0, '0);
      rects_left = rects_left - 16'd1;
      field_idx = 0;
      word = '0;
      stage = (rects_left != 0) ? ST_RECT_HDR : ST_MSG;
    endfunction

    function bit outside_fb();
      return (int'(rect_x) + int'(rect_w) > int'(cfg.fb_width)) ||
             (int'(rect_y) + int'(rect_h) > int'(cfg.fb_height));
    endfunction

    // Advance the parser by one accepted request and queue the events it causes.
    function void take_byte(logic [7:0] b);
      int unsigned n0, i;
      logic [31:0] v, rv, gv, bv;
      event_t e;
      if (halted) return;
      n0 = pending_events.size();
      case (stage)
        ST_MSG: begin
          field_idx = 0;
          word = '0;
          if (b == MsgUpdate) stage = ST_FBU_PAD;
          else if (b == MsgCutText) stage = ST_CUT_PAD;
          else raise_fault();
        end
        ST_FBU_PAD: stage = ST_FBU_COUNT;
        ST_FBU_COUNT: begin
          word = {word[23:0], b};
          field_idx++;
          if (field_idx >= 2) begin
            rects_left = word[15:0];
            field_idx = 0;
            word = '0;
            stage = (rects_left != 0) ? ST_RECT_HDR : ST_MSG;
          end
        end
        ST_RECT_HDR: begin
          i = field_idx;
          if (i < 2) rect_x = {rect_x[7:0], b};
          else if (i < 4) rect_y = {rect_y[7:0], b};
          else if (i < 6) rect_w = {rect_w[7:0], b};
          else if (i < 8) rect_h = {rect_h[7:0], b};
          else word = {word[23:0], b};
          field_idx = (i + 1) & 15;
          if (i >= 11) begin
            field_idx = 0;
            if (word == EncRaw) begin
              if (outside_fb() || cfg.pixel_bits != PixelBitsOk) begin
                raise_fault();
              end else if (rect_w == 0 || rect_h == 0) begin
                close_rect();
              end else begin
                col = '0;
                row = '0;
                word = '0;
                stage = ST_RAW_PIX;
              end
            end else if (word == EncCopy) begin
              if (outside_fb()) begin
                raise_fault();
              end else begin
                word = '0;
                stage = ST_COPY_SRC;
              end
            end else begin
              raise_fault();
            end
          end
        end
        ST_RAW_PIX: begin
          word = {word[23:0], b};
          field_idx++;
          if (field_idx >= 4) begin
            v = cfg.pixel_big_endian ? word : {word[7:0], word[15:8], word[23:16], word[31:24]};
            rv = v >> cfg.red_lsb;
            gv = v >> cfg.green_lsb;
            bv = v >> cfg.blue_lsb;
            add_event(EV_PIXEL, rect_x + col, rect_y + row, '0, '0, rv[7:0], gv[7:0], bv[7:0]);
            field_idx = 0;
            word = '0;
            col = col + 16'd1;
            if (col >= rect_w) begin
              col = '0;
              row = row + 16'd1;
              if (row >= rect_h) close_rect();
            end
          end
        end
        ST_COPY_SRC: begin
          field_idx++;
          if (field_idx >= 4) close_rect();
        end
        ST_CUT_PAD: begin
          field_idx++;
          if (field_idx >= 3) begin
            field_idx = 0;
            word = '0;
            stage = ST_CUT_LEN;
          end
        end
        ST_CUT_LEN: begin
          word = {word[23:0], b};
          field_idx++;
          if (field_idx >= 4) begin
            field_idx = 0;
            if (word > CutLimit) begin
              raise_fault();
            end else begin
              skip_left = word[25:0];
              stage = (skip_left != 0) ? ST_CUT_SKIP : ST_MSG;
            end
            word = '0;
          end
        end
        ST_CUT_SKIP: begin
          skip_left = skip_left - 26'd1;
          if (skip_left == 0) stage = ST_MSG;
        end
        default: stage = ST_MSG;
      endcase
      if (pending_events.size() > n0) begin
        e = pending_events[pending_events.size() - 1];
        e.last = 1'b1;
        pending_events[pending_events.size() - 1] = e;
      end
    endfunction

    task report(string msg);
      if (mismatches < PrintCap) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task match_event(event_t got);
      event_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d at (%0d,%0d)",
                         got.kind, got.pos_x, got.pos_y));
        return;
      end
      want = pending_events.pop_front();
      compare("event_kind", 16'(got.kind), 16'(want.kind));
      compare("pos_x", got.pos_x, want.pos_x);
      compare("pos_y", got.pos_y, want.pos_y);
      compare("area_width", got.area_w, want.area_w);
      compare("area_height", got.area_h, want.area_h);
      compare("red", 16'(got.red), 16'(want.red));
      compare("green", 16'(got.green), 16'(want.green));
      compare("blue", 16'(got.blue), 16'(want.blue));
      compare("last", 16'(got.last), 16'(want.last));
    endtask

    task check_leftover();
      foreach (pending_events[k])
        report($sformatf("missing event kind %0d at (%0d,%0d)", pending_events[k].kind,
                         pending_events[k].pos_x, pending_events[k].pos_y));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                rx_valid_i;
  logic                rx_ready_o;
  logic [7:0]          rx_byte_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                ev_valid_o;
  logic                ev_ready_i;
  logic [1:0]          event_kind_o;
  logic [15:0]         pos_x_o, pos_y_o, area_width_o, area_height_o;
  logic [7:0]          red_o, green_o, blue_o;
  logic                last_o;

  fb_event_tracker model;
  logic [7:0]      tx_bytes[$];
  int unsigned     bytes_sent;
  int unsigned     rx_idle_pct = 37;
  int unsigned     ev_idle_pct = 37;
  int unsigned     cycles;

  rfb_server_message_parser u_dut (
    .clk_i, .rst_ni, .rx_valid_i, .rx_ready_o, .rx_byte_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .ev_valid_o, .ev_ready_i, .event_kind_o, .pos_x_o, .pos_y_o,
    .area_width_o, .area_height_o, .red_o, .green_o, .blue_o, .last_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_rfb_server_message_parser: errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    ev_ready_i <= ($urandom_range(0, 99) >= ev_idle_pct);
  end

  always @(posedge clk_i) begin : ev_monitor
    event_t got;
    if (rst_ni && ev_valid_o && ev_ready_i) begin
      got.kind   = ev_kind_e'(event_kind_o);
      got.pos_x  = pos_x_o;
      got.pos_y  = pos_y_o;
      got.area_w = area_width_o;
      got.area_h = area_height_o;
      got.red    = red_o;
      got.green  = green_o;
      got.blue   = blue_o;
      got.last   = last_o;
      model.match_event(got);
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void put8(logic [7:0] v);
    tx_bytes.push_back(v);
  endfunction

  function automatic void put16(logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  function automatic void add_rect(bit raw);
    logic [15:0] fw, fh, w, h, x, y;
    int unsigned wmax, hmax;
    fw = model.cfg.fb_width;
    fh = model.cfg.fb_height;
    if (raw) begin
      // keep raw areas tiny; pixels dominate the byte count
      wmax = (fw < 4) ? fw : 4;
      hmax = (fh < 4) ? fh : 4;
      w = (wmax == 0 || $urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, wmax));
      h = (hmax == 0 || $urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, hmax));
    end else begin
      w = 16'($urandom_range(0, fw));
      h = 16'($urandom_range(0, fh));
    end
    x = ($urandom_range(0, 3) == 0) ? fw - w : 16'($urandom_range(0, fw - w));
    y = ($urandom_range(0, 3) == 0) ? fh - h : 16'($urandom_range(0, fh - h));
    put16(x);
    put16(y);
    put16(w);
    put16(h);
    put32(raw ? EncRaw : EncCopy);
    repeat (raw ? 4 * int'(w) * int'(h) : 4) put8(rand_byte());
  endfunction

  function automatic void add_update();
    int unsigned n;
    bit raw_ok;
    raw_ok = (model.cfg.pixel_bits == PixelBitsOk);
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    put8(MsgUpdate);
    put8(rand_byte());
    put16(16'(n));
    repeat (n) add_rect(raw_ok && $urandom_range(0, 9) < 6);
  endfunction

  function automatic void add_cut_text();
    int unsigned len;
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = $urandom_range(25, 400);
      default: len = $urandom_range(1, 24);
    endcase
    put8(MsgCutText);
    repeat (3) put8(rand_byte());
    put32(len);
    repeat (len) put8(rand_byte());
  endfunction

  function automatic cfg_t pick_setting(int ph);
    cfg_t c;
    c.fb_width         = 16'($urandom_range(1, 300));
    c.fb_height        = 16'($urandom_range(1, 300));
    c.red_lsb          = 5'($urandom_range(0, 31));
    c.green_lsb        = 5'($urandom_range(0, 31));
    c.blue_lsb         = 5'($urandom_range(0, 31));
    c.pixel_bits       = PixelBitsOk;
    c.pixel_big_endian = 1'($urandom_range(0, 1));
    case (ph)
      0: begin
        c.fb_width = 16'hffff;
        c.fb_height = 16'hffff;
        c.red_lsb = 5'd31;
        c.green_lsb = 5'd0;
        c.blue_lsb = 5'd24;
        c.pixel_big_endian = 1'b1;
      end
      1: begin
        c.fb_width = '0;
        c.fb_height = '0;
        c.red_lsb = '0;
        c.green_lsb = '0;
        c.blue_lsb = '0;
        c.pixel_big_endian = 1'b0;
      end
      3: c.pixel_bits = 6'($urandom_range(8, 31));
      5: begin
        c.fb_width = 16'd1;
        c.fb_height = 16'd1;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    model.take_byte(b);
    bytes_sent++;
  endtask

  task automatic flush_bytes();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  // Drop valid and hold until every queued event has drained, plus some slack.
  task automatic wait_drained();
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    while (model.pending_events.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    model.set_reg(idx, val);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_FB_WIDTH, c.fb_width);
    write_reg(REG_FB_HEIGHT, c.fb_height);
    write_reg(REG_RED_LSB, 16'(c.red_lsb));
    write_reg(REG_GREEN_LSB, 16'(c.green_lsb));
    write_reg(REG_BLUE_LSB, 16'(c.blue_lsb));
    write_reg(REG_PIXEL_BITS, 16'(c.pixel_bits));
    write_reg(REG_PIXEL_BIG_ENDIAN, 16'(c.pixel_big_endian));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t        c;
    fault_e      fault;
    logic [7:0]  bad_type;
    logic [15:0] x, y, w, h;
    logic [31:0] enc;
    rst_ni      = 1'b0;
    rx_valid_i  = 1'b0;
    rx_byte_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_FB_WIDTH;
    cfg_data_i  = '0;
    ev_ready_i  = 1'b0;
    bytes_sent  = 0;
    cycles      = 0;
    model = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty update, empty cut text, then a single corner pixel ending its rectangle
    put8(MsgUpdate);
    put8(8'hff);
    put16(16'd0);
    put8(MsgCutText);
    repeat (3) put8(8'h00);
    put32(32'd0);
    put8(MsgUpdate);
    put8(8'h00);
    put16(16'd1);
    put16(16'd63);
    put16(16'd63);
    put16(16'd1);
    put16(16'd1);
    put32(EncRaw);
    put8(8'hff);
    put8(8'h00);
    put8(8'h80);
    put8(8'h01);
    flush_bytes();

    for (int ph = 0; ph < NumSettings; ph++) begin
      wait_drained();
      load_config(pick_setting(ph));
      rx_idle_pct = (ph == 2) ? 0 : 37;
      ev_idle_pct = rx_idle_pct;
      while (bytes_sent < (ph + 1) * (RandomBytes / NumSettings)) begin
        if ($urandom_range(0, 3) == 0) add_cut_text();
        else add_update();
        flush_bytes();
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
    end

    // the error flag is sticky, so exactly one fault closes the run
    wait_drained();
    fault = fault_e'($urandom_range(0, 4));
    c = pick_setting(-1);
    c.fb_width  = 16'($urandom_range(1, 100));
    c.fb_height = 16'($urandom_range(1, 100));
    if (fault == BAD_DEPTH) c.pixel_bits = 6'($urandom_range(8, 31));
    load_config(c);
    case (fault)
      BAD_TYPE: begin
        do bad_type = 8'($urandom_range(0, 255));
        while (bad_type == MsgUpdate || bad_type == MsgCutText);
        put8(bad_type);
      end
      BAD_TEXT_LEN: begin
        put8(MsgCutText);
        repeat (3) put8(rand_byte());
        put32($urandom_range(CutLimit + 1, 32'hffff_ffff));
      end
      default: begin
        x = '0;
        y = '0;
        w = 16'd1;
        h = 16'd1;
        enc = EncRaw;
        if (fault == BAD_ENCODING) begin
          do enc = $urandom();
          while (enc == EncRaw || enc == EncCopy);
        end else if (fault == BAD_BOUNDS) begin
          enc = $urandom_range(0, 1) ? EncCopy : EncRaw;
          if ($urandom_range(0, 1)) begin
            x = 16'($urandom_range(0, c.fb_width));
            w = c.fb_width - x + 16'd1 + 16'($urandom_range(0, 3));
          end else begin
            y = 16'($urandom_range(0, c.fb_height));
            h = c.fb_height - y + 16'd1 + 16'($urandom_range(0, 3));
          end
        end
        put8(MsgUpdate);
        put8(rand_byte());
        put16(16'd1);
        put16(x);
        put16(y);
        put16(w);
        put16(h);
        put32(enc);
      end
    endcase
    repeat (20) put8(rand_byte());
    flush_bytes();
    wait_drained();
    model.check_leftover();

    if (model.mismatches == 0) begin
      $display("tb_rfb_server_message_parser: clean");
    end else begin
      $display("tb_rfb_server_message_parser: errors");
    end
    $finish;
  end

endmodule
